// ===== hdl/gla_pkg.sv =====
`default_nettype none

package gla_pkg;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_MUTE    = 2'd2,
        KIND_UNMUTE  = 2'd3
    } kind_t;

    // internal alert level; warmup shows as normal
    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_WARNING = 2'd1,
        ST_ALARM   = 2'd2,
        ST_WARMUP  = 2'd3
    } alert_state_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WARN_THR  = 2'd0,
        REG_CRIT_THR  = 2'd1,
        REG_ALERTS_EN = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_reg_t;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MUTE_MS_W  = 27;   // 2047 min * 60000 ms fits

    localparam logic [31:0] WARMUP_TIME_MS    = 32'd60000;
    localparam logic [16:0] HYSTERESIS        = 17'd50;
    localparam logic [31:0] WARN_BEEP_PERIOD  = 32'd300000;
    localparam logic [31:0] ALARM_BEEP_PERIOD = 32'd30000;
    localparam logic [15:0] MS_PER_MINUTE     = 16'd60000;

    localparam logic [15:0] WARN_THR_RST  = 16'd800;
    localparam logic [15:0] CRIT_THR_RST  = 16'd1200;
    localparam logic        ALERTS_EN_RST = 1'b1;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] co2_ppm;
        logic [31:0] now_ms;
        logic        quiet_time;
        logic [10:0] mute_minutes;
    } item_in_t;

    typedef struct packed {
        logic [1:0] level;
        logic       beep_warning;
        logic       beep_alarm;
        logic       muted;
    } item_out_t;

    // alert unit results: output flags and next values of its timers
    typedef struct packed {
        logic        beep_warning;
        logic        beep_alarm;
        logic        muted;
        logic [31:0] mute_deadline;
        logic [31:0] last_warn;
        logic [31:0] last_alarm;
    } alert_upd_t;

    function automatic logic [1:0] vis_level(input alert_state_t st);
        vis_level = (st == ST_WARMUP) ? 2'(ST_NORMAL) : 2'(st);
    endfunction

    // deadline still ahead within half the counter range; zero means off
    function automatic logic mute_running(input logic [31:0] deadline,
                                          input logic [31:0] now);
        logic [31:0] diff;
        diff = now - deadline;
        mute_running = (deadline != 32'd0) && diff[31];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gla_level.sv =====
`default_nettype none

module gla_level (
    input  wire gla_pkg::kind_t        kind,
    input  wire logic [15:0]           co2_ppm,
    input  wire logic [31:0]           now_ms,
    input  wire logic [31:0]           warmup_start,
    input  wire logic [15:0]           warn_thr,
    input  wire logic [15:0]           crit_thr,
    input  wire gla_pkg::alert_state_t state,
    output gla_pkg::alert_state_t      state_next
);

    logic [31:0] elapsed;
    logic        in_warmup;
    logic [16:0] up;
    logic        ge_crit, ge_warn, up_lt_warn, up_lt_crit;
    gla_pkg::alert_state_t sample_next;

    assign elapsed    = now_ms - warmup_start;
    assign in_warmup  = elapsed < gla_pkg::WARMUP_TIME_MS;
    assign up         = {1'b0, co2_ppm} + gla_pkg::HYSTERESIS;
    assign ge_crit    = co2_ppm >= crit_thr;
    assign ge_warn    = co2_ppm >= warn_thr;
    assign up_lt_warn = up < {1'b0, warn_thr};
    assign up_lt_crit = up < {1'b0, crit_thr};

    always_comb begin
        sample_next = state;
        if (in_warmup) begin
            sample_next = gla_pkg::ST_WARMUP;
        end else begin
            unique case (state)
                gla_pkg::ST_WARMUP, gla_pkg::ST_NORMAL: begin
                    if (ge_crit)      sample_next = gla_pkg::ST_ALARM;
                    else if (ge_warn) sample_next = gla_pkg::ST_WARNING;
                    else              sample_next = gla_pkg::ST_NORMAL;
                end
                gla_pkg::ST_WARNING: begin
                    if (ge_crit)         sample_next = gla_pkg::ST_ALARM;
                    else if (up_lt_warn) sample_next = gla_pkg::ST_NORMAL;
                end
                gla_pkg::ST_ALARM: begin
                    if (up_lt_crit)
                        sample_next = ge_warn ? gla_pkg::ST_WARNING : gla_pkg::ST_NORMAL;
                end
                default: sample_next = state;
            endcase
        end
    end

    always_comb begin
        unique case (kind)
            gla_pkg::KIND_SAMPLE:  state_next = sample_next;
            gla_pkg::KIND_RESTART: state_next = gla_pkg::ST_WARMUP;
            default:               state_next = state;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/gla_alert.sv =====
`default_nettype none

module gla_alert (
    input  wire gla_pkg::kind_t            kind,
    input  wire logic [1:0]                level,
    input  wire logic [31:0]               now_ms,
    input  wire logic                      quiet_time,
    input  wire logic                      alerts_en,
    input  wire logic [gla_pkg::MUTE_MS_W-1:0] mute_ms,
    input  wire logic [31:0]               mute_deadline,
    input  wire logic [31:0]               last_warn,
    input  wire logic [31:0]               last_alarm,
    output gla_pkg::alert_upd_t            upd
);

    logic        muted_now;
    logic        allowed;
    logic        warn_due, alarm_due;
    logic [31:0] new_deadline;

    assign muted_now    = gla_pkg::mute_running(mute_deadline, now_ms);
    assign allowed      = alerts_en && !quiet_time && !muted_now;
    // zero stamp reads as never beeped
    assign warn_due     = (last_warn == 32'd0) ||
                          ((now_ms - last_warn) >= gla_pkg::WARN_BEEP_PERIOD);
    assign alarm_due    = (last_alarm == 32'd0) ||
                          ((now_ms - last_alarm) >= gla_pkg::ALARM_BEEP_PERIOD);
    assign new_deadline = now_ms + {{(32 - gla_pkg::MUTE_MS_W){1'b0}}, mute_ms};

    always_comb begin
        upd.beep_warning  = 1'b0;
        upd.beep_alarm    = 1'b0;
        upd.muted         = muted_now;
        upd.mute_deadline = mute_deadline;
        upd.last_warn     = last_warn;
        upd.last_alarm    = last_alarm;
        unique case (kind)
            gla_pkg::KIND_SAMPLE: begin
                if (allowed && level == 2'(gla_pkg::ST_WARNING) && warn_due) begin
                    upd.beep_warning = 1'b1;
                    upd.last_warn    = now_ms;
                end
                if (allowed && level == 2'(gla_pkg::ST_ALARM) && alarm_due) begin
                    upd.beep_alarm = 1'b1;
                    upd.last_alarm = now_ms;
                end
            end
            gla_pkg::KIND_MUTE: begin
                // now - (now + p) has bit 31 set exactly when p is nonzero
                upd.mute_deadline = new_deadline;
                upd.muted = (mute_ms != '0) && (new_deadline != 32'd0);
            end
            gla_pkg::KIND_UNMUTE: begin
                upd.mute_deadline = 32'd0;
                upd.muted         = 1'b0;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/gas_level_alarm_controller.sv =====
// Flow: an accepted item waits in the input register; its result is registered into the
//   result register, which drives m_valid, once that register is empty or being taken.
// Throughput: one item per cycle; the input register and result register
//   both advance whenever the result register is empty or being taken.
// Reset (aresetn low, synchronous): both stages empty, thresholds 800/1200,
//   alerts enabled, level warmup, warmup start, mute and beep stamps zero.
`default_nettype none

module gas_level_alarm_controller (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire gla_pkg::item_in_t               s_item,
    // result items
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output gla_pkg::item_out_t                   m_result,
    // configuration writes
    input  wire logic                            cfg_wr_en,
    input  wire gla_pkg::cfg_reg_t               cfg_addr,
    input  wire logic [gla_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // ---- configuration ----
    logic [15:0] warn_thr_reg;
    logic [15:0] crit_thr_reg;
    logic        alerts_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_thr_reg  <= gla_pkg::WARN_THR_RST;
            crit_thr_reg  <= gla_pkg::CRIT_THR_RST;
            alerts_en_reg <= gla_pkg::ALERTS_EN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gla_pkg::REG_WARN_THR:  warn_thr_reg  <= cfg_wdata;
                gla_pkg::REG_CRIT_THR:  crit_thr_reg  <= cfg_wdata;
                gla_pkg::REG_ALERTS_EN: alerts_en_reg <= cfg_wdata[0];
                default: ;   // no register there
            endcase
        end
    end

    // ---- input stage ----
    // the mute length in ms is worked out on capture so the deadline
    // add sits alone in the next stage
    gla_pkg::item_in_t                 in_item_reg;
    logic [gla_pkg::MUTE_MS_W-1:0]     in_mute_ms_reg;
    logic [gla_pkg::MUTE_MS_W-1:0]     in_mute_ms_next;
    logic                              in_valid_reg;
    logic                              advance;
    logic                              s_accept;

    assign advance         = in_valid_reg && (!m_valid || m_ready);
    assign s_ready         = !in_valid_reg || advance;
    assign s_accept        = s_valid && s_ready;
    assign in_mute_ms_next = gla_pkg::MUTE_MS_W'(s_item.mute_minutes) *
                             gla_pkg::MUTE_MS_W'(gla_pkg::MS_PER_MINUTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg    <= s_item;
            in_mute_ms_reg <= in_mute_ms_next;
        end
    end

    // ---- block state ----
    gla_pkg::alert_state_t state_reg;
    gla_pkg::alert_state_t state_next;
    logic [31:0]           warmup_start_reg;
    logic [31:0]           mute_deadline_reg;
    logic [31:0]           last_warn_reg;
    logic [31:0]           last_alarm_reg;
    gla_pkg::alert_upd_t   upd;
    logic [1:0]            level_next;

    gla_level u_level (
        .kind         (in_item_reg.kind),
        .co2_ppm      (in_item_reg.co2_ppm),
        .now_ms       (in_item_reg.now_ms),
        .warmup_start (warmup_start_reg),
        .warn_thr     (warn_thr_reg),
        .crit_thr     (crit_thr_reg),
        .state        (state_reg),
        .state_next   (state_next)
    );

    // level after the item drives the beep decision
    assign level_next = gla_pkg::vis_level(state_next);

    gla_alert u_alert (
        .kind          (in_item_reg.kind),
        .level         (level_next),
        .now_ms        (in_item_reg.now_ms),
        .quiet_time    (in_item_reg.quiet_time),
        .alerts_en     (alerts_en_reg),
        .mute_ms       (in_mute_ms_reg),
        .mute_deadline (mute_deadline_reg),
        .last_warn     (last_warn_reg),
        .last_alarm    (last_alarm_reg),
        .upd           (upd)
    );

    // state moves with the item into the result register, so the next
    // item in the input stage already sees it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= gla_pkg::ST_WARMUP;
            warmup_start_reg  <= 32'd0;
            mute_deadline_reg <= 32'd0;
            last_warn_reg     <= 32'd0;
            last_alarm_reg    <= 32'd0;
        end else if (advance) begin
            state_reg         <= state_next;
            mute_deadline_reg <= upd.mute_deadline;
            last_warn_reg     <= upd.last_warn;
            last_alarm_reg    <= upd.last_alarm;
            if (in_item_reg.kind == gla_pkg::KIND_RESTART) begin
                warmup_start_reg <= in_item_reg.now_ms;
            end
        end
    end

    // ---- result stage ----
    logic               m_valid_reg;
    gla_pkg::item_out_t m_result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_result_reg.level        <= level_next;
            m_result_reg.beep_warning <= upd.beep_warning;
            m_result_reg.beep_alarm   <= upd.beep_alarm;
            m_result_reg.muted        <= upd.muted;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // ---- checks ----
    // an accepted item always lands in the input stage
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted item not held in input stage");

    // an item leaving the input stage always produces a result
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced item produced no result");

    // an alarm beep stamps the item's time
    a_alarm_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && upd.beep_alarm) |=> (last_alarm_reg == $past(in_item_reg.now_ms)))
        else $error("alarm beep time not recorded");

    // a warning beep is only reported at warning level and stamps the item's time
    a_warn_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && upd.beep_warning) |=>
            (m_result.level == 2'(gla_pkg::ST_WARNING) &&
             last_warn_reg == $past(in_item_reg.now_ms)))
        else $error("warning beep without warning level");

endmodule

`default_nettype wire
